>>> design/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types and codes shared by the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // command codes carried by an input transaction
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RESET     = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_BIT  = 3'd3,
    CMD_READ_BYTE = 3'd4,
    CMD_POWER_ON  = 3'd5
  } cmd_e;

  // line driver codes
  typedef enum logic [1:0] {
    DRV_REL  = 2'd0,
    DRV_LOW  = 2'd1,
    DRV_HIGH = 2'd2
  } drive_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_REST    = 3'd2,
    CFG_WRITE_LOW     = 3'd3,
    CFG_WRITE_HOLD    = 3'd4,
    CFG_READ_LOW      = 3'd5,
    CFG_READ_SAMPLE   = 3'd6,
    CFG_READ_REST     = 3'd7
  } cfg_idx_e;

  // bus sequencer phases, one-hot
  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_RST_LOW   = 11'b000_0000_0010,
    PH_RST_WAIT  = 11'b000_0000_0100,
    PH_RST_REST  = 11'b000_0000_1000,
    PH_WR_LOW    = 11'b000_0001_0000,
    PH_WR_HOLD   = 11'b000_0010_0000,
    PH_WR_REC    = 11'b000_0100_0000,
    PH_RD_LOW    = 11'b000_1000_0000,
    PH_RD_WAIT   = 11'b001_0000_0000,
    PH_RD_SAMPLE = 11'b010_0000_0000,
    PH_RD_REST   = 11'b100_0000_0000
  } phase_e;

  localparam int unsigned CntW  = 16;
  localparam int unsigned ByteW = 8;
  localparam logic [3:0]  BitsPerByte = 4'd8;

endpackage

>>> design/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire master for up to two buses, advanced by one 1 us tick per input
// transaction. Each transaction is one tick and may carry a command (bus
// reset with presence detect, byte write, bit read, byte read, strong power
// on) for the selected bus; each tick yields exactly one result transaction
// with both line drivers, busy/done, presence and read data. One transaction
// is taken per clock cycle: the tick is worked out by the phase sequencer
// between the state registers and the result register, so throughput is one
// tick per cycle into a registered result, and a held-off result only stalls
// the input once the result register is full. Timing registers may be
// written only while no operation is running.
// ----------------------------------------------------------------------------
module onewire_bus_master
  import owm_pkg::*;
#(
  parameter int unsigned RECOVERY_TICKS = 2,
  parameter int unsigned BUS_COUNT      = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic        bus_select_i,
  input  logic [7:0]  write_data_i,
  input  logic        line0_level_i,
  input  logic        line1_level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  line0_drive_o,
  output logic [1:0]  line1_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        presence_found_o,
  output logic [7:0]  read_byte_out_o,
  output logic        command_refused_o
);

  // timing registers
  logic [CntW-1:0]  reset_low_q, presence_wait_q, reset_rest_q;
  logic [ByteW-1:0] write_low_q, write_hold_q, read_low_q, read_sample_q, read_rest_q;

  // sequencer state
  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  tick_q, tick_d;
  logic [3:0]       bits_q, bits_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic             bus_q, bus_d;
  cmd_e             op_q, op_d;
  logic             pres_q, pres_d;
  drive_e           drive_q [BUS_COUNT];
  drive_e           drive_d [BUS_COUNT];
  drive_e           drive1_d;

  // result register
  logic             out_valid_q;
  drive_e           res_drive0_q, res_drive1_q;
  logic             res_busy_q, res_done_q, res_pres_q, res_refused_q;
  logic [ByteW-1:0] res_rd_q;

  // per-tick working values
  phase_e           cur_phase;
  logic [CntW-1:0]  cur_cnt;
  logic [3:0]       cur_bits;
  logic [ByteW-1:0] cur_shift;
  logic             accept, bus_ok, pwr_on, busy, done, refused, line, to_idle;
  drive_e           tick_drive;
  logic [ByteW-1:0] rd_out;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign bus_ok     = (int'(bus_select_i) < BUS_COUNT);

  function automatic logic [CntW-1:0] min_one(input logic [CntW-1:0] v);
    return (v == '0) ? CntW'(1) : v;
  endfunction

  function automatic logic [CntW-1:0] phase_len(input phase_e ph);
    logic [CntW-1:0] len;
    unique case (ph)
      PH_RST_LOW:   len = min_one(reset_low_q);
      PH_RST_WAIT:  len = min_one(presence_wait_q);
      PH_RST_REST:  len = reset_rest_q;
      PH_WR_LOW:    len = min_one(CntW'(write_low_q));
      PH_WR_HOLD:   len = min_one(CntW'(write_hold_q));
      PH_WR_REC:    len = CntW'(RECOVERY_TICKS);
      PH_RD_LOW:    len = min_one(CntW'(read_low_q));
      PH_RD_WAIT:   len = CntW'(read_sample_q);
      PH_RD_SAMPLE: len = CntW'(1);
      PH_RD_REST:   len = CntW'(read_rest_q);
      default:      len = CntW'(1);
    endcase
    return len;
  endfunction

  always_comb begin
    cur_phase = phase_q;
    cur_cnt   = tick_q;
    cur_bits  = bits_q;
    cur_shift = shift_q;
    bus_d     = bus_q;
    op_d      = op_q;
    pwr_on    = 1'b0;
    refused   = 1'b0;

    // command decode
    if (phase_q != PH_IDLE) begin
      refused = (command_i != CMD_TICK);
    end else if (bus_ok && (command_i == CMD_RESET || command_i == CMD_WRITE ||
                            command_i == CMD_READ_BIT || command_i == CMD_READ_BYTE ||
                            command_i == CMD_POWER_ON)) begin
      bus_d = bus_select_i;
      op_d  = cmd_e'(command_i);
      priority if (command_i == CMD_POWER_ON) begin
        pwr_on = 1'b1;
      end else if (command_i == CMD_RESET) begin
        cur_phase = PH_RST_LOW;
        cur_bits  = '0;
        cur_shift = '0;
      end else if (command_i == CMD_WRITE) begin
        cur_phase = PH_WR_LOW;
        cur_bits  = BitsPerByte;
        cur_shift = write_data_i;
      end else if (command_i == CMD_READ_BIT) begin
        cur_phase = PH_RD_LOW;
        cur_bits  = 4'd1;
        cur_shift = '0;
      end else begin
        cur_phase = PH_RD_LOW;
        cur_bits  = BitsPerByte;
        cur_shift = '0;
      end
      if (!pwr_on) begin
        cur_cnt = phase_len(cur_phase);
      end
    end

    // tick of the running phase
    busy       = (cur_phase != PH_IDLE);
    line       = bus_d ? line1_level_i : line0_level_i;
    phase_d    = cur_phase;
    tick_d     = cur_cnt;
    bits_d     = cur_bits;
    shift_d    = cur_shift;
    pres_d     = pres_q;
    to_idle    = 1'b0;
    done       = pwr_on;
    rd_out     = '0;

    unique case (cur_phase)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: tick_drive = DRV_LOW;
      PH_WR_HOLD: tick_drive = cur_shift[0] ? DRV_HIGH : DRV_LOW;
      default:    tick_drive = DRV_REL;
    endcase

    if (busy) begin
      tick_d = (cur_cnt != '0) ? cur_cnt - CntW'(1) : cur_cnt;
      if (cur_cnt <= CntW'(1)) begin
        unique case (cur_phase)
          PH_RST_LOW:  phase_d = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres_d  = !line;
            phase_d = (reset_rest_q != '0) ? PH_RST_REST : PH_IDLE;
          end
          PH_WR_LOW:   phase_d = PH_WR_HOLD;
          PH_WR_HOLD:  phase_d = PH_WR_REC;
          PH_WR_REC: begin
            shift_d = cur_shift >> 1;
            bits_d  = (cur_bits != '0) ? cur_bits - 4'd1 : cur_bits;
            phase_d = (bits_d != '0) ? PH_WR_LOW : PH_IDLE;
          end
          PH_RD_LOW:   phase_d = (read_sample_q != '0) ? PH_RD_WAIT : PH_RD_SAMPLE;
          PH_RD_WAIT:  phase_d = PH_RD_SAMPLE;
          PH_RD_SAMPLE: begin
            shift_d = {line, cur_shift[ByteW-1:1]};
            if (read_rest_q != '0) begin
              phase_d = PH_RD_REST;
            end else begin
              // no rest time: the slot closes on the sampling tick
              bits_d  = (cur_bits != '0) ? cur_bits - 4'd1 : cur_bits;
              phase_d = (bits_d != '0) ? PH_RD_LOW : PH_IDLE;
            end
          end
          PH_RD_REST: begin
            bits_d  = (cur_bits != '0) ? cur_bits - 4'd1 : cur_bits;
            phase_d = (bits_d != '0) ? PH_RD_LOW : PH_IDLE;
          end
          default:     phase_d = PH_IDLE;
        endcase
        if (phase_d == PH_IDLE) begin
          tick_d  = '0;
          to_idle = 1'b1;
          done    = 1'b1;
          if (op_d == CMD_READ_BIT || op_d == CMD_READ_BYTE) begin
            rd_out = shift_d;
          end
        end else begin
          tick_d = phase_len(phase_d);
        end
      end
    end

    for (int b = 0; b < BUS_COUNT; b++) begin
      drive_d[b] = drive_q[b];
      if (int'(bus_d) == b) begin
        if (pwr_on) begin
          drive_d[b] = DRV_HIGH;
        end else if (busy) begin
          drive_d[b] = to_idle ? DRV_REL : tick_drive;
        end
      end
    end
  end

  generate
    if (BUS_COUNT > 1) begin : g_two_bus
      assign drive1_d = drive_d[1];
    end else begin : g_one_bus
      assign drive1_d = DRV_REL;
    end
  endgenerate

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q     <= 16'd500;
      presence_wait_q <= 16'd70;
      reset_rest_q    <= 16'd430;
      write_low_q     <= 8'd4;
      write_hold_q    <= 8'd60;
      read_low_q      <= 8'd6;
      read_sample_q   <= 8'd4;
      read_rest_q     <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RESET_LOW:     reset_low_q     <= cfg_wdata_i;
        CFG_PRESENCE_WAIT: presence_wait_q <= cfg_wdata_i;
        CFG_RESET_REST:    reset_rest_q    <= cfg_wdata_i;
        CFG_WRITE_LOW:     write_low_q     <= cfg_wdata_i[ByteW-1:0];
        CFG_WRITE_HOLD:    write_hold_q    <= cfg_wdata_i[ByteW-1:0];
        CFG_READ_LOW:      read_low_q      <= cfg_wdata_i[ByteW-1:0];
        CFG_READ_SAMPLE:   read_sample_q   <= cfg_wdata_i[ByteW-1:0];
        CFG_READ_REST:     read_rest_q     <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state, advanced once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      bus_q   <= 1'b0;
      op_q    <= CMD_TICK;
      pres_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      bus_q   <= bus_d;
      op_q    <= op_d;
      pres_q  <= pres_d;
    end
  end

  for (genvar gb = 0; gb < BUS_COUNT; gb++) begin : g_drive
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        drive_q[gb] <= DRV_REL;
      end else if (accept) begin
        drive_q[gb] <= drive_d[gb];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_drive0_q  <= drive_d[0];
      res_drive1_q  <= drive1_d;
      res_busy_q    <= busy;
      res_done_q    <= done;
      res_pres_q    <= pres_d;
      res_rd_q      <= rd_out;
      res_refused_q <= refused;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign line0_drive_o     = res_drive0_q;
  assign line1_drive_o     = res_drive1_q;
  assign busy_res_o        = res_busy_q;
  assign done_res_o        = res_done_q;
  assign presence_found_o  = res_pres_q;
  assign read_byte_out_o   = res_rd_q;
  assign command_refused_o = res_refused_q;

  // a refused command only happens during a running operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && command_refused_o) |-> busy_res_o)
    else $error("refused command reported outside a running operation");

  // read data only appears on the tick an operation completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_byte_out_o != '0) |-> done_res_o)
    else $error("read data without done");

  // an operation never goes idle with slots outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (bits_q == '0))
    else $error("idle with bits left");

  // a running phase always has ticks left to count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (tick_q != '0))
    else $error("running phase with empty tick counter");

endmodule

>>> verif/onewire_bus_master_test.sv
// ----------------------------------------------------------------------------
// onewire_bus_master_test
// Self-checking bench for the two-bus 1-Wire master. Every input transaction
// is one tick and yields one result transaction, so each accepted tick is run
// through a local model of the bus sequencer and the result compared field by
// field. Bus reset, byte write, bit and byte read and power on are exercised
// under the reset timing, the range minima, all zeros, all ones and random
// short timings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module onewire_bus_master_test
  import owm_pkg::*;
;

  localparam int unsigned RecoveryTicks = 2;
  localparam int unsigned BusCount      = 2;
  localparam int          CycleLimit    = 200_000;
  // command codes the block does not define
  localparam logic [2:0]  CmdSpareLo    = 3'd6;
  localparam logic [2:0]  CmdSpareHi    = 3'd7;

  typedef enum int {
    PROF_LOW,
    PROF_ZERO,
    PROF_MAX,
    PROF_SHORT,
    PROF_WIDE
  } timing_profile_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic             bus;
    logic [ByteW-1:0] wdata;
    logic             line0;
    logic             line1;
  } tick_t;

  typedef struct packed {
    logic [1:0]       drv0;
    logic [1:0]       drv1;
    logic             busy;
    logic             done;
    logic             presence;
    logic [ByteW-1:0] rbyte;
    logic             refused;
  } tick_report_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  tick_t       on_wire;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  line0_drive;
  logic [1:0]  line1_drive;
  logic        busy_res;
  logic        done_res;
  logic        presence_found;
  logic [7:0]  read_byte_out;
  logic        command_refused;

  // sequencer model state
  logic [CntW-1:0]  timing [8];
  phase_e           seq_phase;
  logic [CntW-1:0]  ticks_left;
  logic [3:0]       bits_left;
  logic [ByteW-1:0] shreg;
  logic             act_bus;
  logic [2:0]       act_op;
  drive_e           drv_state [2];
  logic             presence;

  tick_t        ticks_to_send [$];
  tick_report_t reports_due [$];
  tick_report_t fresh;
  tick_report_t want;

  int  ticks_pushed;
  int  ticks_accepted;
  int  ticks_checked;
  int  ops_done;
  int  refusals;
  int  settings;
  int  fail_cnt;
  int  cycle_cnt;
  int  in_gap;
  int  out_gap;
  bit  in_taken;
  bit  calm;

  onewire_bus_master #(
    .RECOVERY_TICKS(RecoveryTicks),
    .BUS_COUNT     (BusCount)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (on_wire.cmd),
    .bus_select_i     (on_wire.bus),
    .write_data_i     (on_wire.wdata),
    .line0_level_i    (on_wire.line0),
    .line1_level_i    (on_wire.line1),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .line0_drive_o    (line0_drive),
    .line1_drive_o    (line1_drive),
    .busy_res_o       (busy_res),
    .done_res_o       (done_res),
    .presence_found_o (presence_found),
    .read_byte_out_o  (read_byte_out),
    .command_refused_o(command_refused)
  );

  function automatic logic [CntW-1:0] min1(logic [CntW-1:0] v);
    return (v != '0) ? v : CntW'(1);
  endfunction

  function automatic logic [CntW-1:0] seg_len(phase_e ph);
    case (ph)
      PH_RST_LOW:   return min1(timing[CFG_RESET_LOW]);
      PH_RST_WAIT:  return min1(timing[CFG_PRESENCE_WAIT]);
      PH_RST_REST:  return timing[CFG_RESET_REST];
      PH_WR_LOW:    return min1(timing[CFG_WRITE_LOW]);
      PH_WR_HOLD:   return min1(timing[CFG_WRITE_HOLD]);
      PH_WR_REC:    return CntW'(RecoveryTicks);
      PH_RD_LOW:    return min1(timing[CFG_READ_LOW]);
      PH_RD_WAIT:   return timing[CFG_READ_SAMPLE];
      PH_RD_REST:   return timing[CFG_READ_REST];
      default:      return CntW'(1);
    endcase
  endfunction

  function automatic drive_e seg_drive(phase_e ph);
    case (ph)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: return DRV_LOW;
      PH_WR_HOLD: begin
        if (shreg[0]) return DRV_HIGH;
        return DRV_LOW;
      end
      default: return DRV_REL;
    endcase
  endfunction

  // end of a phase: shifts, bit counting and the presence sample happen here
  function automatic phase_e next_seg(phase_e ph, logic lvl);
    case (ph)
      PH_RST_LOW:  return PH_RST_WAIT;
      PH_RST_WAIT: begin
        presence = ~lvl;
        return PH_RST_REST;
      end
      PH_WR_LOW:   return PH_WR_HOLD;
      PH_WR_HOLD:  return PH_WR_REC;
      PH_WR_REC: begin
        shreg = shreg >> 1;
        if (bits_left != 0) bits_left--;
        if (bits_left != 0) return PH_WR_LOW;
        return PH_IDLE;
      end
      PH_RD_LOW:    return PH_RD_WAIT;
      PH_RD_WAIT:   return PH_RD_SAMPLE;
      PH_RD_SAMPLE: begin
        shreg = {lvl, shreg[ByteW-1:1]};
        return PH_RD_REST;
      end
      PH_RD_REST: begin
        if (bits_left != 0) bits_left--;
        if (bits_left != 0) return PH_RD_LOW;
        return PH_IDLE;
      end
      default: return PH_IDLE;
    endcase
  endfunction

  task automatic sequence_tick(input tick_t t, output tick_report_t r);
    logic   b;
    logic   lvl;
    phase_e ph;
    r = '0;
    if (seq_phase != PH_IDLE) begin
      if (t.cmd != CMD_TICK) r.refused = 1'b1;
    end else if (t.cmd >= CMD_RESET && t.cmd <= CMD_POWER_ON && t.bus < BusCount) begin
      act_bus = t.bus;
      act_op  = t.cmd;
      case (t.cmd)
        CMD_POWER_ON: begin
          drv_state[t.bus] = DRV_HIGH;
          r.done = 1'b1;
        end
        CMD_RESET: begin
          seq_phase = PH_RST_LOW;
          bits_left = '0;
          shreg     = '0;
        end
        CMD_WRITE: begin
          seq_phase = PH_WR_LOW;
          bits_left = BitsPerByte;
          shreg     = t.wdata;
        end
        CMD_READ_BIT: begin
          seq_phase = PH_RD_LOW;
          bits_left = 4'd1;
          shreg     = '0;
        end
        default: begin
          seq_phase = PH_RD_LOW;
          bits_left = BitsPerByte;
          shreg     = '0;
        end
      endcase
      if (seq_phase != PH_IDLE) ticks_left = seg_len(seq_phase);
    end

    if (seq_phase != PH_IDLE) begin
      b   = act_bus;
      lvl = b ? t.line1 : t.line0;
      r.busy = 1'b1;
      drv_state[b] = seg_drive(seq_phase);
      r.drv0 = drv_state[0];
      r.drv1 = drv_state[1];
      if (ticks_left != 0) ticks_left--;
      if (ticks_left == 0) begin
        // zero-length phases are passed over within the same tick
        ph = next_seg(seq_phase, lvl);
        while (ph != PH_IDLE && seg_len(ph) == 0) ph = next_seg(ph, lvl);
        seq_phase = ph;
        if (ph == PH_IDLE) begin
          ticks_left   = '0;
          r.done       = 1'b1;
          drv_state[b] = DRV_REL;
          if (act_op == CMD_READ_BIT || act_op == CMD_READ_BYTE) r.rbyte = shreg;
        end else begin
          ticks_left = seg_len(ph);
        end
      end
    end else begin
      r.drv0 = drv_state[0];
      r.drv1 = drv_state[1];
    end
    r.presence = presence;
  endtask

  // length in ticks of a whole operation under the current timing
  function automatic int op_ticks(logic [2:0] cmd);
    int slot;
    case (cmd)
      CMD_RESET:
        return min1(timing[CFG_RESET_LOW]) + min1(timing[CFG_PRESENCE_WAIT])
             + timing[CFG_RESET_REST];
      CMD_WRITE:
        return int'(BitsPerByte) * (min1(timing[CFG_WRITE_LOW])
             + min1(timing[CFG_WRITE_HOLD]) + RecoveryTicks);
      CMD_READ_BIT, CMD_READ_BYTE: begin
        slot = min1(timing[CFG_READ_LOW]) + timing[CFG_READ_SAMPLE] + 1
             + timing[CFG_READ_REST];
        if (cmd == CMD_READ_BIT) return slot;
        return int'(BitsPerByte) * slot;
      end
      default: return 1;
    endcase
  endfunction

  // lvl below zero: random wire levels, otherwise both wires held at lvl
  function automatic tick_t make_tick(int lvl);
    tick_t t;
    t.cmd   = CMD_TICK;
    t.bus   = 1'($urandom_range(0, 1));
    t.wdata = 8'($urandom_range(0, 255));
    t.line0 = (lvl < 0) ? 1'($urandom_range(0, 1)) : lvl[0];
    t.line1 = (lvl < 0) ? 1'($urandom_range(0, 1)) : lvl[0];
    return t;
  endfunction

  task automatic push_tick(tick_t t);
    ticks_to_send.push_back(t);
    ticks_pushed++;
  endtask

  // a command followed by enough plain ticks to see it through, give or take
  task automatic push_op(logic [2:0] cmd, logic bus, logic [7:0] data, int lvl, int extra);
    tick_t t;
    int    n;
    t       = make_tick(lvl);
    t.cmd   = cmd;
    t.bus   = bus;
    t.wdata = data;
    push_tick(t);
    n = op_ticks(cmd) - 1 + extra;
    for (int i = 0; i < n; i++) push_tick(make_tick(lvl));
  endtask

  // wait until every tick is through and the sequencer has gone idle
  task automatic settle();
    do begin
      while (ticks_accepted != ticks_pushed || reports_due.size() != 0) @(negedge clk);
      if (seq_phase != PH_IDLE) begin
        for (int i = 0; i < int'(ticks_left); i++) push_tick(make_tick(-1));
      end
    end while (seq_phase != PH_IDLE);
  endtask

  function automatic logic [15:0] pick_timing(timing_profile_e prof, cfg_idx_e idx);
    logic wide;
    wide = (idx <= CFG_RESET_REST);
    case (prof)
      PROF_LOW: begin
        if (idx == CFG_RESET_REST || idx == CFG_READ_SAMPLE || idx == CFG_READ_REST)
          return 16'd0;
        return 16'd1;
      end
      PROF_ZERO:  return 16'h0000;
      PROF_MAX:   return 16'hFFFF;
      PROF_SHORT: return 16'($urandom_range(0, 3));
      default:    return wide ? 16'($urandom_range(0, 12)) : 16'($urandom_range(0, 4));
    endcase
  endfunction

  task automatic set_timing(timing_profile_e prof);
    logic [15:0] v;
    settle();
    repeat (3) @(negedge clk);
    for (int i = CFG_RESET_LOW; i <= CFG_READ_REST; i++) begin
      v = pick_timing(prof, cfg_idx_e'(i));
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_wdata <= v;
      timing[i] = (cfg_idx_e'(i) >= CFG_WRITE_LOW) ? (v & 16'h00FF) : v;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_batch(int n);
    int         first;
    int         pick;
    int         lvl;
    int         extra;
    logic [2:0] cmd;
    first = ticks_pushed;
    while (ticks_pushed - first < n) begin
      pick = $urandom_range(0, 99);
      lvl  = ($urandom_range(0, 9) < 3) ? int'($urandom_range(0, 1)) : -1;
      if (pick < 8) begin
        push_op(3'($urandom_range(CmdSpareLo, CmdSpareHi)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), lvl, 0);
      end else if (pick < 16) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) push_tick(make_tick(lvl));
      end else begin
        cmd   = 3'($urandom_range(CMD_RESET, CMD_POWER_ON));
        pick  = $urandom_range(0, 99);
        extra = 0;
        // some slack after the operation, or a next command sent too early
        if (pick >= 80) extra = -int'($urandom_range(1, 6));
        else if (pick >= 60) extra = $urandom_range(1, 4);
        push_op(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), lvl, extra);
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always #5 clk = ~clk;

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (ticks_to_send.size() != 0) begin
        on_wire  <= ticks_to_send.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) in_gap = $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  // monitor: check each result transaction, model each accepted tick
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          fail_cnt++;
          $display("%0t: result transaction with nothing outstanding", $time);
        end else begin
          want = reports_due.pop_front();
          check_field("line0_drive", 8'(want.drv0), 8'(line0_drive));
          check_field("line1_drive", 8'(want.drv1), 8'(line1_drive));
          check_field("busy_res", 8'(want.busy), 8'(busy_res));
          check_field("done_res", 8'(want.done), 8'(done_res));
          check_field("presence_found", 8'(want.presence), 8'(presence_found));
          check_field("read_byte_out", want.rbyte, read_byte_out);
          check_field("command_refused", 8'(want.refused), 8'(command_refused));
          ticks_checked++;
          if (want.done) ops_done++;
          if (want.refused) refusals++;
        end
      end
      if (in_valid && in_ready) begin
        sequence_tick(on_wire, fresh);
        reports_due.push_back(fresh);
        ticks_accepted++;
        in_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("onewire_bus_master_test: done, errors");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_RESET_LOW;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    on_wire    = '0;
    out_ready  = 1'b0;
    calm       = 1'b0;
    in_taken   = 1'b0;
    in_gap     = 0;
    out_gap    = 0;
    seq_phase  = PH_IDLE;
    ticks_left = '0;
    bits_left  = '0;
    shreg      = '0;
    act_bus    = 1'b0;
    act_op     = '0;
    presence   = 1'b0;
    drv_state[0] = DRV_REL;
    drv_state[1] = DRV_REL;
    timing[CFG_RESET_LOW]     = 16'd500;
    timing[CFG_PRESENCE_WAIT] = 16'd70;
    timing[CFG_RESET_REST]    = 16'd430;
    timing[CFG_WRITE_LOW]     = 16'd4;
    timing[CFG_WRITE_HOLD]    = 16'd60;
    timing[CFG_READ_LOW]      = 16'd6;
    timing[CFG_READ_SAMPLE]   = 16'd4;
    timing[CFG_READ_REST]     = 16'd50;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // timing straight out of reset
    push_op(CMD_POWER_ON, 1'b1, 8'h00, -1, 0);
    push_op(CMD_READ_BIT, 1'b0, 8'h00, 1, 0);

    // shortest legal timing
    set_timing(PROF_LOW);
    push_op(CMD_RESET, 1'b0, 8'h00, 0, 0);
    push_op(CMD_RESET, 1'b1, 8'h00, 1, 0);
    push_op(CMD_WRITE, 1'b0, 8'h00, -1, 0);
    push_op(CMD_WRITE, 1'b1, 8'hFF, -1, 0);
    push_op(CMD_WRITE, 1'b0, 8'hA5, -1, 0);
    push_op(CMD_READ_BIT, 1'b0, 8'h00, 1, 0);
    push_op(CMD_READ_BIT, 1'b1, 8'h00, 0, 0);
    push_op(CMD_READ_BYTE, 1'b0, 8'h00, 1, 0);
    push_op(CMD_READ_BYTE, 1'b1, 8'h00, 0, 0);
    push_op(CMD_READ_BYTE, 1'b0, 8'h00, -1, 0);
    push_op(CMD_POWER_ON, 1'b0, 8'h00, -1, 0);
    push_op(CMD_POWER_ON, 1'b1, 8'h00, -1, 0);
    push_op(CMD_WRITE, 1'b0, 8'h81, -1, 0);
    push_op(CmdSpareLo, 1'b0, 8'h00, -1, 0);
    push_op(CmdSpareHi, 1'b1, 8'h00, -1, 0);
    // commands landing on a busy sequencer
    push_op(CMD_WRITE, 1'b0, 8'hC3, -1, 3 - op_ticks(CMD_WRITE));
    push_op(CmdSpareHi, 1'b1, 8'h00, -1, 0);
    push_op(CMD_READ_BYTE, 1'b1, 8'h00, -1, 0);

    // zero everywhere: skipped rests, minimum one tick elsewhere
    set_timing(PROF_ZERO);
    push_op(CMD_RESET, 1'b1, 8'h00, 0, 0);
    push_op(CMD_WRITE, 1'b1, 8'h96, -1, 0);
    push_op(CMD_READ_BIT, 1'b0, 8'h00, -1, 0);
    push_op(CMD_READ_BYTE, 1'b1, 8'h00, -1, 0);

    // longest timing, one full read slot
    set_timing(PROF_MAX);
    push_op(CMD_READ_BIT, 1'b0, 8'h00, -1, 0);

    set_timing(PROF_SHORT);
    random_batch(130);
    set_timing(PROF_WIDE);
    random_batch(130);
    set_timing(PROF_SHORT);
    random_batch(130);
    calm = 1'b1;
    set_timing(PROF_SHORT);
    random_batch(130);

    settle();
    repeat (8) @(negedge clk);
    $display("%0d ticks checked over %0d timing settings", ticks_checked, settings);
    $display("%0d operations completed, %0d commands refused while busy", ops_done, refusals);
    if (fail_cnt == 0) begin
      $display("onewire_bus_master_test: done, clean");
    end else begin
      $display("onewire_bus_master_test: done, errors");
    end
    $finish;
  end

endmodule
